>>> design/spq_pkg.sv
// package for the sorted priority queue: operation and status codes,
// request, response and slot entry types; used by the slot memory, sequencer and top level
package spq_pkg;

    // operation codes carried in the kind field
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    // status codes of a response
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // one stored slot
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] key;
    } entry_t;

    // one request
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] item_id;
        logic [31:0] item_key;
    } req_t;

    // one response
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_id;
        logic [31:0] result_key;
        logic        queue_empty;
        logic [15:0] head_id;
        logic [31:0] head_key;
    } rsp_t;

endpackage

>>> design/spq_req_if.sv
// request channel of the sorted priority queue: valid, ready and payload
// no dependencies
interface spq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] item_id;
    logic [31:0] item_key;

    modport source (output valid, output kind, output item_id, output item_key, input ready);
    modport sink   (input valid, input kind, input item_id, input item_key, output ready);
endinterface

>>> design/spq_rsp_if.sv
// response channel of the sorted priority queue: valid, ready and payload
// no dependencies
interface spq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [31:0] result_key;
    logic        queue_empty;
    logic [15:0] head_id;
    logic [31:0] head_key;

    modport source (output valid, output status, output result_id, output result_key,
                    output queue_empty, output head_id, output head_key, input ready);
    modport sink   (input valid, input status, input result_id, input result_key,
                    input queue_empty, input head_id, input head_key, output ready);
endinterface

>>> design/spq_slot_ram.sv
// slot memory of the sorted priority queue: one write port, one read port,
// registered read data; depends on spq_pkg
module spq_slot_ram
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> design/spq_ctrl.sv
// sequencer of the sorted priority queue: walks the slot memory one entry
// per cycle for insert, pop and lookup; depends on spq_pkg and spq_slot_ram
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  req_t req_data,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);
    localparam logic [CW-1:0] TWO      = CW'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_POP,
        S_LKP,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    entry_t        head_reg, head_next;
    entry_t        op_reg, op_next;
    logic [1:0]    res_status_reg, res_status_next;
    entry_t        res_reg, res_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec2;
    logic [CW-1:0] count_dec;

    spq_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_dec   = idx_reg - ONE;
    assign idx_inc   = idx_reg + ONE;
    assign idx_dec2  = idx_reg - TWO;
    assign count_dec = count_reg - ONE;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);

    // response fields, head masked to zero when empty
    always_comb
    begin
        rsp_data.status      = res_status_reg;
        rsp_data.result_id   = res_reg.id;
        rsp_data.result_key  = res_reg.key;
        rsp_data.queue_empty = (count_reg == '0);
        rsp_data.head_id     = (count_reg == '0) ? 16'd0 : head_reg.id;
        rsp_data.head_key    = (count_reg == '0) ? 32'd0 : head_reg.key;
    end

    // sequencer next state and memory control
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        op_next         = op_reg;
        res_status_next = res_status_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[AW-1:0];
        ram_wdata       = op_reg;
        ram_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next.id      = req_data.item_id;
                    op_next.key     = req_data.item_key;
                    res_status_next = ST_OK;
                    res_next        = '0;
                    state_next      = S_DONE;
                    case (req_data.kind)
                        KIND_INSERT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                // walk back from the tail
                                idx_next   = count_reg;
                                ram_raddr  = count_dec[AW-1:0];
                                state_next = S_INS;
                            end
                        end
                        KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                res_next = head_reg;
                                if (count_reg == ONE)
                                begin
                                    count_next = '0;
                                end
                                else
                                begin
                                    // shift the rest up by one slot
                                    idx_next   = ONE;
                                    ram_raddr  = ONE[AW-1:0];
                                    state_next = S_POP;
                                end
                            end
                        end
                        KIND_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                idx_next   = '0;
                                ram_raddr  = '0;
                                state_next = S_LKP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_INS:
            begin
                // read data holds slot idx-1 unless idx is zero
                ram_we = 1'b1;
                if ((idx_reg == '0) || (ram_rdata.key <= op_reg.key))
                begin
                    ram_wdata  = op_reg;
                    count_next = count_reg + ONE;
                    state_next = S_DONE;
                    if (idx_reg == '0)
                    begin
                        head_next = op_reg;
                    end
                end
                else
                begin
                    ram_wdata = ram_rdata;
                    idx_next  = idx_dec;
                    ram_raddr = idx_dec2[AW-1:0];
                end
            end

            S_POP:
            begin
                // read data holds slot idx, moved to idx-1
                ram_we    = 1'b1;
                ram_waddr = idx_dec[AW-1:0];
                ram_wdata = ram_rdata;
                if (idx_reg == ONE)
                begin
                    head_next = ram_rdata;
                end
                if (idx_inc == count_reg)
                begin
                    count_next = count_dec;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[AW-1:0];
                end
            end

            S_LKP:
            begin
                // read data holds slot idx
                if (ram_rdata.id == op_reg.id)
                begin
                    res_next   = ram_rdata;
                    state_next = S_DONE;
                end
                else if (idx_inc == count_reg)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[AW-1:0];
                end
            end

            S_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        head_reg       <= head_next;
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        res_reg        <= res_next;
    end

endmodule

>>> design/sorted_priority_queue_unit.sv
// top level of the sorted priority queue: sequencer plus response register
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   kind, item_id, item_key
//  rsp      out  valid/ready   status, result_id, result_key, queue_empty,
//                              head_id, head_key
//
// one request at a time; the slot memory is walked one entry per cycle
// through its single read and write port. an insert walks back from the
// tail, moving entries down until its position; a pop moves the entries
// behind the head up by one slot; a lookup scans from the head until a
// match or the tail; an error or no-op needs no walk.
// reset clears the entry count, the sequencer and the output valid only.
// a stalled response holds in the output register; the next request is taken
// once the sequencer has handed over its response.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    req_t req_data;
    rsp_t ctrl_rsp;
    logic ctrl_rsp_valid;
    logic ctrl_rsp_ready;
    logic out_valid_reg;
    rsp_t out_data_reg;

    assign req_data.kind     = req.kind;
    assign req_data.item_id  = req.item_id;
    assign req_data.item_key = req.item_key;

    spq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_data  (req_data),
        .req_ready (req.ready),
        .rsp_valid (ctrl_rsp_valid),
        .rsp_ready (ctrl_rsp_ready),
        .rsp_data  (ctrl_rsp)
    );

    // output register takes a response when empty or being drained
    assign ctrl_rsp_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl_rsp_ready)
        begin
            out_valid_reg <= ctrl_rsp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_rsp_valid && ctrl_rsp_ready)
        begin
            out_data_reg <= ctrl_rsp;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_data_reg.status;
    assign rsp.result_id   = out_data_reg.result_id;
    assign rsp.result_key  = out_data_reg.result_key;
    assign rsp.queue_empty = out_data_reg.queue_empty;
    assign rsp.head_id     = out_data_reg.head_id;
    assign rsp.head_key    = out_data_reg.head_key;

endmodule

>>> bench/tb_sorted_priority_queue_unit.sv
// testbench for sorted_priority_queue_unit: directed and random request traffic,
// checked against an in-bench sorted-slot predictor; depends on spq_pkg,
// spq_req_if, spq_rsp_if and the design top level
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;
    import spq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // kind code with no operation behind it
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_unit #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predictor state: sorted slots, head in slot 0
    entry_t queue_slots [DEPTH];
    int     queue_count;

    // responses still owed by the block, oldest first
    rsp_t   owed_rsp [$];

    int mismatch_count;
    int cycle_count;
    int burst_left;
    bit sender_gappy;
    rx_style_t rx_style;
    logic [15:0] rx_pattern = 16'b1101_1001_1110_0101;
    logic hold_active;
    event hold_go;

    // coverage tallies for the closing summary
    int n_insert_ok, n_full, n_pop_ok, n_pop_empty, n_found, n_not_found, n_unused;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // apply one request to the predictor and return the response it owes
    function automatic rsp_t apply_queue_op(req_t r);
        rsp_t o;
        int   pos;
        int   i;
        o = '0;
        case (r.kind)
            KIND_INSERT:
            begin
                if (queue_count >= DEPTH)
                begin
                    o.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    // equal keys go behind the ones already queued
                    pos = 0;
                    while (pos < queue_count && queue_slots[pos].key <= r.item_key)
                        pos++;
                    for (i = queue_count; i > pos; i--)
                        queue_slots[i] = queue_slots[i - 1];
                    queue_slots[pos].id  = r.item_id;
                    queue_slots[pos].key = r.item_key;
                    queue_count++;
                    o.status = ST_OK;
                    n_insert_ok++;
                end
            end
            KIND_POP:
            begin
                if (queue_count == 0)
                begin
                    o.status = ST_EMPTY;
                    n_pop_empty++;
                end
                else
                begin
                    o.result_id  = queue_slots[0].id;
                    o.result_key = queue_slots[0].key;
                    for (i = 1; i < queue_count; i++)
                        queue_slots[i - 1] = queue_slots[i];
                    queue_count--;
                    o.status = ST_OK;
                    n_pop_ok++;
                end
            end
            KIND_LOOKUP:
            begin
                // first match from the head wins
                o.status = ST_NOT_FOUND;
                for (i = 0; i < queue_count; i++)
                begin
                    if (o.status == ST_NOT_FOUND && queue_slots[i].id == r.item_id)
                    begin
                        o.status     = ST_OK;
                        o.result_id  = queue_slots[i].id;
                        o.result_key = queue_slots[i].key;
                    end
                end
                if (o.status == ST_OK)
                    n_found++;
                else
                    n_not_found++;
            end
            default:
            begin
                o.status = ST_OK;
                n_unused++;
            end
        endcase
        o.queue_empty = (queue_count == 0);
        if (queue_count != 0)
        begin
            o.head_id  = queue_slots[0].id;
            o.head_key = queue_slots[0].key;
        end
        return o;
    endfunction

    function automatic string format_rsp(rsp_t r);
        return $sformatf("status=%0d id=%h key=%h empty=%0b head_id=%h head_key=%h",
                         r.status, r.result_id, r.result_key, r.queue_empty,
                         r.head_id, r.head_key);
    endfunction

    // offer one request, wait for acceptance, record the owed response
    task automatic send_request(input logic [1:0] kind, input logic [15:0] id,
                                input logic [31:0] key);
        req_t r;
        r.kind     = kind;
        r.item_id  = id;
        r.item_key = key;
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.item_id  <= id;
        req_ch.item_key <= key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        owed_rsp.push_back(apply_queue_op(r));
        // at the end of a burst a gappy sender drops valid and pauses
        burst_left--;
        if (sender_gappy && burst_left <= 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 7))
            0, 1, 2: return 16'($urandom_range(0, 7));
            3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // lookups mostly aim at identifiers that are queued
    function automatic logic [15:0] pick_lookup_id();
        if (queue_count > 0 && $urandom_range(0, 9) < 7)
            return queue_slots[$urandom_range(0, queue_count - 1)].id;
        return pick_id();
    endfunction

    // empty queue: pop, lookup and the unused code
    task automatic test_empty_queue();
        send_request(KIND_POP, 16'h0000, 32'h0000_0000);
        send_request(KIND_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(KIND_UNUSED, 16'h1234, 32'h5678_9ABC);
    endtask

    // key extremes, tie order, duplicate ids, lookup hit and miss
    task automatic test_order_and_lookup();
        send_request(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 16'h0000, 32'h0000_0000);
        send_request(KIND_INSERT, 16'h0007, 32'h0000_0005);
        send_request(KIND_INSERT, 16'h0008, 32'h0000_0005);
        send_request(KIND_INSERT, 16'h0007, 32'h0000_0003);
        send_request(KIND_LOOKUP, 16'h0007, 32'h0000_0000);
        send_request(KIND_LOOKUP, 16'hFFFF, 32'h0000_0000);
        send_request(KIND_LOOKUP, 16'h1234, 32'h0000_0000);
        send_request(KIND_UNUSED, 16'h0000, 32'h0000_0000);
    endtask

    // fill every slot, then one insert too many
    task automatic test_fill_to_full();
        while (queue_count < DEPTH)
            send_request(KIND_INSERT, pick_id(), pick_key());
        send_request(KIND_INSERT, 16'hA5A5, 32'h5A5A_5A5A);
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_input_stall();
        int n;
        sender_gappy = 1'b0;
        rx_style     = RX_ALWAYS;
        -> hold_go;
        for (n = 0; n < 24; n++)
        begin
            if (n % 3 == 2)
                send_request(KIND_INSERT, pick_id(), pick_key());
            else
                send_request(KIND_POP, pick_id(), pick_key());
        end
    endtask

    // random phases: filling, draining, mixed and lookup-heavy traffic
    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int mode;
        int roll;
        int n;
        logic [1:0] kind;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len    = $urandom_range(20, 80);
            mode         = $urandom_range(0, 3);
            sender_gappy = ($urandom_range(0, 2) != 0);
            rx_style     = rx_style_t'($urandom_range(0, 2));
            burst_left   = $urandom_range(1, 12);
            for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       kind = roll < 70 ? KIND_INSERT : roll < 85 ? KIND_POP :
                                    roll < 97 ? KIND_LOOKUP : KIND_UNUSED;
                    1:       kind = roll < 15 ? KIND_INSERT : roll < 85 ? KIND_POP :
                                    roll < 97 ? KIND_LOOKUP : KIND_UNUSED;
                    2:       kind = roll < 40 ? KIND_INSERT : roll < 75 ? KIND_POP :
                                    roll < 97 ? KIND_LOOKUP : KIND_UNUSED;
                    default: kind = roll < 25 ? KIND_INSERT : roll < 45 ? KIND_POP :
                                    roll < 97 ? KIND_LOOKUP : KIND_UNUSED;
                endcase
                if (kind == KIND_LOOKUP)
                    send_request(kind, pick_lookup_id(), pick_key());
                else
                    send_request(kind, pick_id(), pick_key());
                sent++;
            end
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status      = rsp_ch.status;
            got.result_id   = rsp_ch.result_id;
            got.result_key  = rsp_ch.result_key;
            got.queue_empty = rsp_ch.queue_empty;
            got.head_id     = rsp_ch.head_id;
            got.head_key    = rsp_ch.head_key;
            if (owed_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: response with none owed: %s", $realtime, format_rsp(got));
            end
            else
            begin
                want = owed_rsp.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                 $realtime, format_rsp(want), format_rsp(got));
                end
            end
        end
    end

    // long receiver hold-off, timed in its own process
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(hold_go);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // receiver ready: steady, random or a rotating pattern
    always @(posedge clk)
    begin
        rx_pattern <= {rx_pattern[14:0], rx_pattern[15]};
        if (hold_active)
            rsp_ch.ready <= 1'b0;
        else
            case (rx_style)
                RX_ALWAYS: rsp_ch.ready <= 1'b1;
                RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                default:   rsp_ch.ready <= rx_pattern[15];
            endcase
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses owed",
                     cycle_count, owed_rsp.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // sequence of tests
    initial
    begin
        queue_count    = 0;
        burst_left     = 4;
        sender_gappy   = 1'b1;
        rx_style       = RX_RANDOM;
        n_insert_ok = 0; n_full = 0; n_pop_ok = 0; n_pop_empty = 0;
        n_found = 0; n_not_found = 0; n_unused = 0;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.kind     <= KIND_INSERT;
        req_ch.item_id  <= 16'h0000;
        req_ch.item_key <= 32'h0000_0000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_order_and_lookup();
        test_fill_to_full();
        test_input_stall();
        test_random_traffic();

        // drain
        req_ch.valid <= 1'b0;
        sender_gappy  = 1'b1;
        rx_style      = RX_ALWAYS;
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("inserts %0d ok / %0d full, pops %0d ok / %0d empty",
                 n_insert_ok, n_full, n_pop_ok, n_pop_empty);
        $display("lookups %0d found / %0d missed, unused codes %0d, %0d mismatching",
                 n_found, n_not_found, n_unused, mismatch_count);
        if (mismatch_count == 0 && owed_rsp.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
design/spq_pkg.sv
design/spq_req_if.sv
design/spq_rsp_if.sv
design/spq_slot_ram.sv
design/spq_ctrl.sv
design/sorted_priority_queue_unit.sv
bench/tb_sorted_priority_queue_unit.sv
